>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL.
// MF3_ASSERT checks on every rising edge outside of reset.
// MF3_ASSERT_NR checks on every rising edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MF3_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define MF3_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MF3_ASSERT(lbl, clk, rstn, prop, msg)

`define MF3_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

>>> sv/mf3_pkg.sv
`timescale 1ns / 1ps

package mf3_pkg;

  // defaults for the top-level parameters
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_PIXEL_BITS = 8;

  // register geometry
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 16;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [WIDTH_BITS-1:0]  RESET_WIDTH  = 11'd1024;
  localparam logic [HEIGHT_BITS-1:0] RESET_HEIGHT = 16'd1024;

  // register index, taken from paddr[2]
  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  // smallest window extent
  localparam int WIN_MIN = 3;

endpackage

>>> sv/mf3_line_mem.sv
`timescale 1ns / 1ps

// Line store: one word per column holding {recent row hmax, older row hmax}.
// Synchronous read; a write to the address being read in
// the same cycle is forwarded to the read result.
module mf3_line_mem #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 16
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q_r;
  logic              fwd_hit_r;
  logic [DATA_W-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      fwd_hit_r  <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : rd_q_r;

endmodule

>>> sv/mf3_out_fifo.sv
`timescale 1ns / 1ps

// Small result queue that decouples the pipeline from the output stall.
module mf3_out_fifo #(
  parameter int DATA_W = 10,
  parameter int DEPTH  = 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [DATA_W-1:0]          push_data,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [DATA_W-1:0]          out_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = slot[rd_ptr_r];
  assign count     = cnt_r;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> sv/max_filter_3x3.sv
`timescale 1ns / 1ps
// max_filter_3x3: 3x3 max filter, stride 1, no padding, raster-order pixels.
// Throughput: one pixel per cycle while in_stall is low, set by the line
//   store read-modify-write of one column per cycle; a 3-entry result
//   queue absorbs output stalls.
// Reset (synchronous, rst_n low): counters, pixel history, queue cleared,
//   width/height back to 1024; the line store is not cleared.

`include "assert_macros.svh"

module max_filter_3x3 import mf3_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel requests
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIXEL_BITS-1:0] in_pixel,
  input  logic                  in_frame_start,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIXEL_BITS-1:0] out_local_max,
  output logic                  out_row_end,
  output logic                  out_frame_end,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int MEM_W      = 2 * PIXEL_BITS;
  localparam int OUT_W      = PIXEL_BITS + 2;
  localparam int FIFO_DEPTH = 3;
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  function automatic logic [PIXEL_BITS-1:0] max2(input logic [PIXEL_BITS-1:0] a,
                                                 input logic [PIXEL_BITS-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers. Index comes from paddr[2]; low bits are ignored.
  // ---------------------------------------------------------------------------
  logic [WIDTH_BITS-1:0]  cfg_width_r;
  logic [HEIGHT_BITS-1:0] cfg_height_r;
  logic                   cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= RESET_WIDTH;
      cfg_height_r <= RESET_HEIGHT;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_IDX_WIDTH:  cfg_width_r  <= pwdata[WIDTH_BITS-1:0];
        REG_IDX_HEIGHT: cfg_height_r <= pwdata[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IDX_WIDTH:  prdata = PDATA_W'(cfg_width_r);
      REG_IDX_HEIGHT: prdata = PDATA_W'(cfg_height_r);
      default:        prdata = '0;
    endcase
  end

  // Effective geometry: width clamped to [3, MAX_WIDTH], height at least 3.
  // Kept as "last index" values so the compares below are plain equalities.
  logic [COL_W-1:0]       wm1;
  logic [HEIGHT_BITS-1:0] hm1;

  always_comb begin
    if (32'(cfg_width_r) < WIN_MIN) begin
      wm1 = COL_W'(WIN_MIN - 1);
    end else if (32'(cfg_width_r) > MAX_WIDTH) begin
      wm1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      wm1 = COL_W'(32'(cfg_width_r) - 1);
    end
    if (32'(cfg_height_r) < WIN_MIN) begin
      hm1 = HEIGHT_BITS'(WIN_MIN - 1);
    end else begin
      hm1 = cfg_height_r - HEIGHT_BITS'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: position tracking, horizontal max, line store read.
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0]       col_cnt_r, col_cnt_nxt;
  logic [HEIGHT_BITS-1:0] row_cnt_r, row_cnt_nxt;
  logic [PIXEL_BITS-1:0]  near_r, far_r;

  logic [COL_W-1:0]       col_raw, col;
  logic [HEIGHT_BITS-1:0] row;
  logic                   last_col, last_row, col_ge2, row_ge2;
  logic [PIXEL_BITS-1:0]  hmax;
  logic                   accept;
  logic [FCNT_W-1:0]      fifo_cnt;

  // s1: item whose line store word is being read this cycle
  logic                   s1_wr_r;      // writes back its column
  logic                   s1_res_r;     // produces a result
  logic [COL_W-1:0]       s1_col_r;
  logic [PIXEL_BITS-1:0]  s1_hmax_r;
  logic                   s1_row_end_r;
  logic                   s1_frame_end_r;

  // Stall once the queue plus the item in flight would fill the queue.
  assign in_stall = (32'(fifo_cnt) + 32'(s1_res_r)) >= FIFO_DEPTH;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    // frame start restarts the position at once
    col_raw  = in_frame_start ? '0 : col_cnt_r;
    row      = in_frame_start ? '0 : row_cnt_r;
    // column past the width (width shrunk mid-row) acts as the row's last
    col      = (col_raw > wm1) ? wm1 : col_raw;
    last_col = (col == wm1);
    last_row = (row >= hm1);
    col_ge2  = (32'(col) >= 2);
    row_ge2  = (32'(row) >= 2);
    hmax     = max2(in_pixel, max2(near_r, far_r));

    if (last_col) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = last_row ? '0 : row + HEIGHT_BITS'(1);
    end else begin
      col_cnt_nxt = col + COL_W'(1);
      row_cnt_nxt = row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      near_r    <= '0;
      far_r     <= '0;
      s1_wr_r   <= 1'b0;
      s1_res_r  <= 1'b0;
    end else begin
      if (accept) begin
        col_cnt_r <= col_cnt_nxt;
        row_cnt_r <= row_cnt_nxt;
        near_r    <= in_pixel;
        far_r     <= near_r;
      end
      s1_wr_r  <= accept && col_ge2;
      s1_res_r <= accept && col_ge2 && row_ge2;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r       <= col;
      s1_hmax_r      <= hmax;
      s1_row_end_r   <= last_col;
      s1_frame_end_r <= last_col && last_row;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: vertical max from the line store, shift the column's history.
  // ---------------------------------------------------------------------------
  logic [MEM_W-1:0]      rd_word;
  logic [PIXEL_BITS-1:0] hmax_recent, hmax_older, vmax;

  mf3_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (MEM_W)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept && col_ge2),
    .rd_addr (col),
    .rd_data (rd_word),
    .wr_en   (s1_wr_r),
    .wr_addr (s1_col_r),
    .wr_data ({s1_hmax_r, hmax_recent})
  );

  assign hmax_recent = rd_word[MEM_W-1:PIXEL_BITS];
  assign hmax_older  = rd_word[PIXEL_BITS-1:0];
  assign vmax        = max2(s1_hmax_r, max2(hmax_recent, hmax_older));

  // ---------------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------------
  logic [OUT_W-1:0] out_word;

  mf3_out_fifo #(
    .DATA_W (OUT_W),
    .DEPTH  (FIFO_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_res_r),
    .push_data ({vmax, s1_row_end_r, s1_frame_end_r}),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_word),
    .count     (fifo_cnt)
  );

  assign out_local_max = out_word[OUT_W-1:2];
  assign out_row_end   = out_word[1];
  assign out_frame_end = out_word[0];

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `MF3_ASSERT(a_no_stall_when_empty, clk, rst_n,
    (fifo_cnt == '0 && !s1_res_r) |-> !in_stall, "stall with nothing in flight")
  `MF3_ASSERT(a_wb_follows_read, clk, rst_n,
    (accept && col_ge2) |=> s1_wr_r, "line store write-back missing")
  `MF3_ASSERT(a_frame_end_on_row_end, clk, rst_n,
    (out_valid && out_frame_end) |-> out_row_end, "frame end without row end")
  `MF3_ASSERT(a_queue_bound, clk, rst_n,
    32'(fifo_cnt) <= FIFO_DEPTH, "result queue overflow")

endmodule

>>> verif/max_filter_checker.sv
`timescale 1ns / 1ps

module max_filter_checker import mf3_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [PIXEL_BITS-1:0] in_pixel,
  input  logic                  in_frame_start,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [PIXEL_BITS-1:0] out_local_max,
  input  logic                  out_row_end,
  input  logic                  out_frame_end,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  input  logic                  pready,
  output int unsigned           fail_count,
  output int unsigned           results_pending
);

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  typedef struct packed {
    pixel_t local_max;
    logic   row_end;
    logic   frame_end;
  } window_t;

  logic [WIDTH_BITS-1:0]  image_width;
  logic [HEIGHT_BITS-1:0] image_height;
  int unsigned            col_count;
  logic [15:0]            row_count;
  pixel_t                 left_near;
  pixel_t                 left_far;
  // per-column horizontal maxima of the two rows above
  pixel_t                 row_max_recent [MAX_WIDTH];
  pixel_t                 row_max_older  [MAX_WIDTH];
  window_t                expected_windows [$];

  function automatic pixel_t brightest(input pixel_t a, input pixel_t b, input pixel_t c);
    pixel_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  task automatic predict_window_max(input pixel_t px, input logic start);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned row;
    pixel_t      hmax;
    logic        last_col;
    logic        last_row;
    window_t     win;
    w = 32'(image_width);
    if (w < WIN_MIN) w = WIN_MIN;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = 32'(image_height);
    if (h < WIN_MIN) h = WIN_MIN;
    if (start) begin
      col_count = 0;
      row_count = '0;
    end
    col = col_count;
    row = 32'(row_count);
    // a column past the (shrunk) width closes the row
    if (col > w - 1) col = w - 1;
    last_col = (col == w - 1);
    last_row = (row >= h - 1);
    if (col >= 2) begin
      hmax = brightest(px, left_near, left_far);
      if (row >= 2) begin
        win.local_max = brightest(hmax, row_max_recent[col], row_max_older[col]);
        win.row_end   = last_col;
        win.frame_end = last_col && last_row;
        expected_windows.push_back(win);
      end
      row_max_older[col]  = row_max_recent[col];
      row_max_recent[col] = hmax;
    end
    left_far  = left_near;
    left_near = px;
    if (last_col) begin
      col_count = 0;
      row_count = last_row ? 16'd0 : 16'(row + 1);
    end else begin
      col_count = col + 1;
    end
  endtask

  task automatic check_window(input window_t got);
    window_t want;
    if (expected_windows.size() == 0) begin
      $error("unexpected result: local_max %0d row_end %0b frame_end %0b",
             got.local_max, got.row_end, got.frame_end);
      fail_count++;
    end else begin
      want = expected_windows.pop_front();
      if (got.local_max !== want.local_max) begin
        $error("local_max: expected %0d, actual %0d", want.local_max, got.local_max);
        fail_count++;
      end
      if (got.row_end !== want.row_end) begin
        $error("row_end: expected %0b, actual %0b", want.row_end, got.row_end);
        fail_count++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0b, actual %0b", want.frame_end, got.frame_end);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    window_t got;
    if (!rst_n) begin
      image_width  = RESET_WIDTH;
      image_height = RESET_HEIGHT;
      col_count    = 0;
      row_count    = '0;
      left_near    = '0;
      left_far     = '0;
      expected_windows.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_IDX_WIDTH) image_width = pwdata[WIDTH_BITS-1:0];
        else image_height = pwdata[HEIGHT_BITS-1:0];
      end
      // drain before predicting: a new request cannot produce a result this edge
      if (out_valid && !out_stall) begin
        got.local_max = out_local_max;
        got.row_end   = out_row_end;
        got.frame_end = out_frame_end;
        check_window(got);
      end
      if (in_valid && !in_stall) predict_window_max(in_pixel, in_frame_start);
    end
    results_pending = expected_windows.size();
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mf3_pkg::*;

  localparam int              PIXEL_BITS    = DEF_PIXEL_BITS;
  localparam int              RANDOM_ITEMS  = 600;
  // margin for the pipeline to run dry before touching registers
  localparam int              SETTLE_CYCLES = 4;
  localparam longint unsigned CYCLE_LIMIT   = 1_000_000;

  // byte addresses: register index sits in paddr[2]
  localparam logic [PADDR_W-1:0] ADDR_IMAGE_WIDTH  = {REG_IDX_WIDTH, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_IMAGE_HEIGHT = {REG_IDX_HEIGHT, 2'b00};

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  localparam pixel_t PIX_MIN = '0;
  localparam pixel_t PIX_MAX = '1;

  // how often a side inserts wait cycles per request
  typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_FULL} idle_mode_e;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  pixel_t             in_pixel;
  logic               in_frame_start;
  logic               out_valid;
  logic               out_stall;
  pixel_t             out_local_max;
  logic               out_row_end;
  logic               out_frame_end;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int unsigned        fail_count;
  int unsigned        results_pending;
  int unsigned        items_sent;
  int unsigned        result_hold;
  idle_mode_e         tx_mode;
  idle_mode_e         rx_mode;
  longint unsigned    cycle_count;

  max_filter_3x3 #(
    .MAX_WIDTH  (DEF_MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_local_max  (out_local_max),
    .out_row_end    (out_row_end),
    .out_frame_end  (out_frame_end),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Watches both channels and the register port, predicts each window max
  // and compares; hands back the mismatch count and the results still owed.
  max_filter_checker #(
    .MAX_WIDTH  (DEF_MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) window_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel        (in_pixel),
    .in_frame_start  (in_frame_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_local_max   (out_local_max),
    .out_row_end     (out_row_end),
    .out_frame_end   (out_frame_end),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // hard stop if the run hangs (lost result, stuck stall)
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic int unsigned draw_wait(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_SOME: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 19) : 0;
      default:   return $urandom_range(0, 19);
    endcase
  endfunction

  // Biased toward the extremes so ties and saturated windows show up often.
  function automatic pixel_t pick_pixel();
    case ($urandom_range(0, 7))
      0:       return PIX_MIN;
      1:       return PIX_MAX;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  // Result side: after each accepted result, hold stall for a drawn number of
  // cycles in which a result is on offer. Counted at the rising edge, driven
  // at the falling edge.
  initial begin
    result_hold = 0;
    out_stall   = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      result_hold <= draw_wait(rx_mode);
    end else if (rst_n && out_valid && result_hold != 0) begin
      result_hold <= result_hold - 1;
    end
  end

  always @(negedge clk) begin
    out_stall <= (result_hold != 0);
  end

  // All stimulus tasks start and end at a falling edge.

  // One register write: setup cycle, access cycle, then idle with psel low so a
  // following write never lowers and raises psel in the same time step.
  task automatic write_register(input logic [PADDR_W-1:0] addr,
                                input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // One pixel request. A zero gap keeps valid high straight into the next
  // request, so valid gets exactly one assignment per falling edge.
  task automatic send_pixel(input pixel_t px, input logic start);
    int unsigned gap;
    gap = draw_wait(tx_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel       <= px;
    in_frame_start <= start;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  // count random pixels; first one carries the given frame_start, the rest
  // may carry a stray restart when noisy
  task automatic send_frame(input logic start, input int unsigned count, input logic noisy);
    for (int i = 0; i < count; i++) begin
      send_pixel(pick_pixel(),
                 (i == 0) ? start : (noisy && $urandom_range(0, 199) == 0));
    end
  endtask

  // Sender holds off until every predicted result has come back, then lets
  // the pipeline run dry (requests with no result may still be in flight).
  task automatic settle();
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int unsigned        cur_w;
    int unsigned        geo_w;
    int unsigned        geo_h;
    int unsigned        frames;
    int unsigned        span;
    int unsigned        cut;
    int unsigned        random_goal;
    int unsigned        size_sel;
    logic               shrink;
    logic               start;
    logic [PDATA_W-1:0] width_val;
    logic [PDATA_W-1:0] height_val;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_pixel       = '0;
    in_frame_start = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    items_sent     = 0;
    tx_mode        = IDLE_NONE;
    rx_mode        = IDLE_NONE;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed: smallest geometry, one window per 3x3 frame ----
    write_register(ADDR_IMAGE_WIDTH, 3);
    write_register(ADDR_IMAGE_HEIGHT, 3);
    tx_mode = IDLE_FULL;
    rx_mode = IDLE_FULL;

    // max sits in the oldest corner: exercises far pixel and older line
    for (int i = 0; i < 9; i++) send_pixel((i == 0) ? PIX_MAX : PIX_MIN, i == 0);
    // no frame_start: counters wrapped at frame end; stale 255s must be gone
    for (int i = 0; i < 9; i++) send_pixel((i == 8) ? pixel_t'(1) : PIX_MIN, 1'b0);
    // partial frame, then a restart mid-row drops it
    send_pixel(PIX_MAX, 1'b0);
    send_pixel(PIX_MAX, 1'b0);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? pixel_t'(128) : PIX_MIN, i == 0);

    // ---- widest geometry: width register at its top value clamps to 1024,
    // height 0 reads as 3. Row 0 wraps after exactly 1024 pixels; a shrink
    // to 4 early in row 1 closes that row, and row 2 gives two windows. ----
    settle();
    write_register(ADDR_IMAGE_WIDTH, 2047);
    write_register(ADDR_IMAGE_HEIGHT, 0);
    tx_mode = IDLE_SOME;
    rx_mode = IDLE_SOME;
    send_frame(1'b1, DEF_MAX_WIDTH + 4, 1'b0);
    settle();
    write_register(ADDR_IMAGE_WIDTH, 4);
    for (int i = 0; i < 5; i++) send_pixel(pick_pixel(), 1'b0);

    // ---- exact maximum width, tallest height: a partial first row only ----
    settle();
    write_register(ADDR_IMAGE_WIDTH, DEF_MAX_WIDTH);
    write_register(ADDR_IMAGE_HEIGHT, 65535);
    send_frame(1'b1, 50, 1'b0);

    // ---- shrink mid-row: column 50 is past the new width of 4, so that
    // pixel closes row 0; of two more rows, row 2 gives windows. Height 1 reads as 3.
    // Every line store column read later was written in rows 0 and 1. ----
    settle();
    write_register(ADDR_IMAGE_WIDTH, 4);
    write_register(ADDR_IMAGE_HEIGHT, 1);
    for (int i = 0; i < 9; i++) send_pixel(pick_pixel(), 1'b0);
    cur_w = 4;

    // ---- random phases ----
    // Line store rule: within one frame the width never grows, so no column
    // is read before rows 0 and 1 of that frame wrote it. A phase that grows
    // the width always opens with frame_start; a shrink phase may land
    // anywhere in a frame (mid-row included) and continues without one.
    random_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < random_goal) begin
      tx_mode = idle_mode_e'($urandom_range(0, 2));
      rx_mode = idle_mode_e'($urandom_range(0, 2));
      shrink  = ($urandom_range(0, 3) == 0);
      if (shrink) begin
        geo_w = $urandom_range(3, (cur_w < 12) ? cur_w : 12);
      end else begin
        size_sel = $urandom_range(0, 9);
        if (size_sel < 7) geo_w = $urandom_range(3, 12);
        else if (size_sel < 9) geo_w = $urandom_range(13, 40);
        else geo_w = $urandom_range(41, 64);
      end
      geo_h = (geo_w > 12) ? $urandom_range(3, 5) : $urandom_range(3, 8);
      // below-minimum register values read back as the 3-pixel minimum
      width_val  = (geo_w == 3 && $urandom_range(0, 1)) ? $urandom_range(0, 2) : geo_w;
      height_val = (geo_h == 3 && $urandom_range(0, 1)) ? $urandom_range(0, 2) : geo_h;

      settle();
      write_register(ADDR_IMAGE_WIDTH, width_val);
      write_register(ADDR_IMAGE_HEIGHT, height_val);
      cur_w = geo_w;

      span   = geo_w * geo_h;
      frames = (geo_w > 12) ? 1 : $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        // last frame sometimes cut short so the next phase lands mid-frame
        cut   = (f == frames - 1 && $urandom_range(0, 3) == 0) ?
                $urandom_range(1, span - 1) : span;
        // later frames often rely on the wrap at frame end instead
        start = (f == 0) ? !shrink : 1'($urandom_range(0, 1));
        send_frame(start, cut, 1'b1);
        // sender backs off until the block has caught up
        if ($urandom_range(0, 19) == 0) settle();
      end
    end

    // ---- drain and verdict ----
    settle();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
